FILE: rtl/tss_pkg.sv
// Package for the thermal safety supervisor: payload and state structs,
// configuration register indexes, fault and event codes, and fixed limits.
// Used by tss_check and thermal_safety_supervisor; depends on nothing.
package tss_pkg;

    localparam int TEMP_BITS   = 12;
    localparam int TIME_BITS   = 32;
    localparam int CUR_BITS    = 15;
    localparam int MARGIN_BITS = 11;
    localparam int DPA_BITS    = 8;
    localparam int PROD_BITS   = 24;
    localparam int CFG_INDEX_BITS = 4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOT_FAULT_LIMIT   = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOT_RATE_LIMIT    = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALARM_ENTER_LEVEL = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALARM_EXIT_LEVEL  = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WARN_ENTER_LEVEL  = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WARN_EXIT_LEVEL   = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CROSS_MARGIN      = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DELTA_PER_AMP     = 4'd7;

    // Controller phases.
    localparam logic [1:0] PHASE_SELF_TEST = 2'd0;
    localparam logic [1:0] PHASE_STARTUP   = 2'd1;
    localparam logic [1:0] PHASE_RAMP_UP   = 2'd2;

    // Fault status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_SENSOR  = 2'd1;
    localparam logic [1:0] STATUS_SUPPLY  = 2'd2;
    localparam logic [1:0] STATUS_THERMAL = 2'd3;

    // Reason codes.
    localparam logic [3:0] REASON_NONE          = 4'd0;
    localparam logic [3:0] REASON_COLD_ERROR    = 4'd1;
    localparam logic [3:0] REASON_HOT_MISSING   = 4'd2;
    localparam logic [3:0] REASON_COLD_LOW      = 4'd3;
    localparam logic [3:0] REASON_COLD_HIGH     = 4'd4;
    localparam logic [3:0] REASON_HOT_LOW       = 4'd5;
    localparam logic [3:0] REASON_HOT_HIGH      = 4'd6;
    localparam logic [3:0] REASON_HOT_LIMIT     = 4'd7;
    localparam logic [3:0] REASON_RUNAWAY       = 4'd8;
    localparam logic [3:0] REASON_SUPPLY_ASYM   = 4'd9;
    localparam logic [3:0] REASON_SUPPLY_ABSENT = 4'd10;
    localparam logic [3:0] REASON_IMPLAUSIBLE   = 4'd11;

    // Cross-check events.
    localparam logic [1:0] EVENT_NONE    = 2'd0;
    localparam logic [1:0] EVENT_ENTERED = 2'd1;
    localparam logic [1:0] EVENT_REPEAT  = 2'd2;
    localparam logic [1:0] EVENT_CLEARED = 2'd3;

    // Fixed limits, tenths of a degree unless noted.
    localparam logic signed [TEMP_BITS-1:0] COLD_MIN_VALID   = TEMP_BITS'(-700);
    localparam logic signed [TEMP_BITS-1:0] COLD_MAX_VALID   = TEMP_BITS'(800);
    localparam logic signed [TEMP_BITS-1:0] HOT_MIN_VALID    = TEMP_BITS'(-550);
    localparam logic signed [TEMP_BITS-1:0] HOT_MAX_VALID    = TEMP_BITS'(1250);
    localparam logic signed [TEMP_BITS-1:0] PLAUS_COLD_MAX   = TEMP_BITS'(-500);
    localparam logic signed [TEMP_BITS-1:0] PLAUS_HOT_THRESH = TEMP_BITS'(150);
    localparam logic [CUR_BITS-1:0]  PLAUS_MIN_CURRENT_MA = CUR_BITS'(500);
    localparam logic [PROD_BITS-1:0] PLAUS_SCALE          = PROD_BITS'(1000);
    localparam logic [TIME_BITS-1:0] PLAUS_GRACE_MS       = TIME_BITS'(180000);
    localparam logic [TIME_BITS-1:0] CROSS_GRACE_MS       = TIME_BITS'(300000);
    localparam logic [TIME_BITS-1:0] REPORT_INTERVAL_MS   = TIME_BITS'(60000);

    // Register reset values.
    localparam logic signed [TEMP_BITS-1:0] HOT_FAULT_LIMIT_RST   = TEMP_BITS'(700);
    localparam logic signed [TEMP_BITS-1:0] HOT_RATE_LIMIT_RST    = TEMP_BITS'(50);
    localparam logic signed [TEMP_BITS-1:0] ALARM_ENTER_LEVEL_RST = TEMP_BITS'(600);
    localparam logic signed [TEMP_BITS-1:0] ALARM_EXIT_LEVEL_RST  = TEMP_BITS'(550);
    localparam logic signed [TEMP_BITS-1:0] WARN_ENTER_LEVEL_RST  = TEMP_BITS'(500);
    localparam logic signed [TEMP_BITS-1:0] WARN_EXIT_LEVEL_RST   = TEMP_BITS'(450);
    localparam logic [MARGIN_BITS-1:0]      CROSS_MARGIN_RST      = MARGIN_BITS'(20);
    localparam logic [DPA_BITS-1:0]         DELTA_PER_AMP_RST     = DPA_BITS'(20);

    typedef struct packed {
        logic signed [TEMP_BITS-1:0] cold_reading;
        logic signed [TEMP_BITS-1:0] hot_reading;
        logic                        cold_sensor_error;
        logic                        hot_sensor_present;
        logic                        supply_asymmetric;
        logic                        supply_any_present;
        logic                        rate_available;
        logic signed [TEMP_BITS-1:0] hot_rise_rate;
        logic [CUR_BITS-1:0]         avg_current_ma;
        logic [1:0]                  phase;
        logic [TIME_BITS-1:0]        ramp_elapsed_ms;
        logic [TIME_BITS-1:0]        now_ms;
    } tss_sample_t;

    typedef struct packed {
        logic [1:0] fault_status;
        logic [3:0] reason_code;
        logic       hot_alarm;
        logic       hot_warning;
        logic       plausibility_warn;
        logic       cross_warn_active;
        logic [1:0] cross_event;
    } tss_result_t;

    typedef struct packed {
        logic signed [TEMP_BITS-1:0] hot_fault_limit;
        logic signed [TEMP_BITS-1:0] hot_rate_limit;
        logic signed [TEMP_BITS-1:0] alarm_enter_level;
        logic signed [TEMP_BITS-1:0] alarm_exit_level;
        logic signed [TEMP_BITS-1:0] warn_enter_level;
        logic signed [TEMP_BITS-1:0] warn_exit_level;
        logic [MARGIN_BITS-1:0]      cross_margin;
        logic [DPA_BITS-1:0]         delta_per_amp;
    } tss_cfg_t;

    typedef struct packed {
        logic                 alarm_flag;
        logic                 warning_flag;
        logic                 cross_flag;
        logic [TIME_BITS-1:0] last_report_time;
    } tss_state_t;

endpackage

FILE: rtl/tss_check.sv
// Evaluation logic for one sensor tick: hysteresis, fault checks, plausibility
// and cross-check. Purely combinational; depends on tss_pkg.
module tss_check
    import tss_pkg::*;
(
    input  tss_sample_t sample,
    input  tss_cfg_t    cfg,
    input  tss_state_t  state,
    output tss_result_t result,
    output tss_state_t  state_next
);

    logic                        alarm_next;
    logic                        warning_next;
    logic                        health_fault;
    logic [3:0]                  sensor_reason;
    logic                        range_fault;
    logic [3:0]                  range_reason;
    logic                        limit_fault;
    logic [3:0]                  thermal_reason;
    logic                        supply_fault;
    logic [3:0]                  supply_reason;
    logic [1:0]                  status;
    logic [3:0]                  reason;
    logic                        skip_plaus;
    logic                        plaus_active;
    logic signed [TEMP_BITS:0]   delta;
    logic signed [PROD_BITS-1:0] delta_scaled;
    logic [CUR_BITS+DPA_BITS-1:0] expect_u;
    logic signed [PROD_BITS-1:0] expect_s;
    logic                        plaus_fail;
    logic                        cross_grace;
    logic signed [TEMP_BITS+1:0] cross_thresh;
    logic signed [TEMP_BITS+1:0] cold_wide;
    logic                        cross_cond;
    logic [TIME_BITS-1:0]        since_report;

    always_comb
    begin
        // Hysteresis flags, levels used as given.
        if (state.alarm_flag)
            alarm_next = !(sample.hot_reading < cfg.alarm_exit_level);
        else
            alarm_next = sample.hot_reading >= cfg.alarm_enter_level;
        if (state.warning_flag)
            warning_next = !(sample.hot_reading < cfg.warn_exit_level);
        else
            warning_next = sample.hot_reading >= cfg.warn_enter_level;

        health_fault  = sample.cold_sensor_error || !sample.hot_sensor_present;
        sensor_reason = sample.cold_sensor_error ? REASON_COLD_ERROR : REASON_HOT_MISSING;

        range_fault = 1'b1;
        if (sample.cold_reading < COLD_MIN_VALID)
            range_reason = REASON_COLD_LOW;
        else if (sample.cold_reading > COLD_MAX_VALID)
            range_reason = REASON_COLD_HIGH;
        else if (sample.hot_reading < HOT_MIN_VALID)
            range_reason = REASON_HOT_LOW;
        else if (sample.hot_reading > HOT_MAX_VALID)
            range_reason = REASON_HOT_HIGH;
        else
        begin
            range_fault  = 1'b0;
            range_reason = REASON_NONE;
        end

        limit_fault = 1'b1;
        if (sample.hot_reading >= cfg.hot_fault_limit)
            thermal_reason = REASON_HOT_LIMIT;
        else if (sample.rate_available && (sample.hot_rise_rate > cfg.hot_rate_limit))
            thermal_reason = REASON_RUNAWAY;
        else
        begin
            limit_fault    = 1'b0;
            thermal_reason = REASON_NONE;
        end

        supply_fault  = sample.supply_asymmetric || !sample.supply_any_present;
        supply_reason = sample.supply_asymmetric ? REASON_SUPPLY_ASYM : REASON_SUPPLY_ABSENT;

        // The most severe fault wins; among sensor-level faults the first check wins.
        if (limit_fault)
        begin
            status = STATUS_THERMAL;
            reason = thermal_reason;
        end
        else if (supply_fault)
        begin
            status = STATUS_SUPPLY;
            reason = supply_reason;
        end
        else if (health_fault)
        begin
            status = STATUS_SENSOR;
            reason = sensor_reason;
        end
        else if (range_fault)
        begin
            status = STATUS_SENSOR;
            reason = range_reason;
        end
        else
        begin
            status = STATUS_OK;
            reason = REASON_NONE;
        end

        // Plausibility: (hot - cold) * 1000 against current * delta_per_amp.
        skip_plaus = (sample.phase == PHASE_STARTUP) ||
                     ((sample.phase == PHASE_RAMP_UP) &&
                      (sample.ramp_elapsed_ms < PLAUS_GRACE_MS));
        plaus_active = !skip_plaus && (sample.cold_reading <= PLAUS_COLD_MAX) &&
                       (sample.avg_current_ma >= PLAUS_MIN_CURRENT_MA) &&
                       (sample.hot_reading < PLAUS_HOT_THRESH);
        delta = $signed({sample.hot_reading[TEMP_BITS-1], sample.hot_reading}) -
                $signed({sample.cold_reading[TEMP_BITS-1], sample.cold_reading});
        delta_scaled = $signed({{(PROD_BITS-TEMP_BITS-1){delta[TEMP_BITS]}}, delta}) *
                       $signed(PLAUS_SCALE);
        expect_u = (CUR_BITS+DPA_BITS)'(sample.avg_current_ma) *
                   (CUR_BITS+DPA_BITS)'(cfg.delta_per_amp);
        expect_s = $signed({{(PROD_BITS-CUR_BITS-DPA_BITS){1'b0}}, expect_u});
        plaus_fail = plaus_active && (delta_scaled < expect_s);

        // Cross-check: cold should sit more than the margin below hot.
        cross_grace = (sample.phase == PHASE_SELF_TEST) ||
                      (sample.phase == PHASE_STARTUP) ||
                      ((sample.phase == PHASE_RAMP_UP) &&
                       (sample.ramp_elapsed_ms < CROSS_GRACE_MS));
        cross_thresh = $signed({{2{sample.hot_reading[TEMP_BITS-1]}}, sample.hot_reading}) -
                       $signed({{(TEMP_BITS+2-MARGIN_BITS){1'b0}}, cfg.cross_margin});
        cold_wide  = $signed({{2{sample.cold_reading[TEMP_BITS-1]}}, sample.cold_reading});
        cross_cond = cold_wide >= cross_thresh;
        since_report = sample.now_ms - state.last_report_time;

        state_next              = state;
        state_next.alarm_flag   = alarm_next;
        state_next.warning_flag = warning_next;

        result.fault_status      = status;
        result.reason_code       = reason;
        result.hot_alarm         = alarm_next;
        result.hot_warning       = warning_next;
        result.plausibility_warn = 1'b0;
        result.cross_event       = EVENT_NONE;

        if (status == STATUS_OK)
        begin
            if (plaus_fail)
            begin
                result.fault_status = STATUS_THERMAL;
                result.reason_code  = REASON_IMPLAUSIBLE;
            end
            else
            begin
                result.plausibility_warn = plaus_active;
                if (!cross_grace)
                begin
                    if (cross_cond)
                    begin
                        if (!state.cross_flag)
                        begin
                            state_next.cross_flag       = 1'b1;
                            state_next.last_report_time = sample.now_ms;
                            result.cross_event          = EVENT_ENTERED;
                        end
                        else if (since_report >= REPORT_INTERVAL_MS)
                        begin
                            state_next.last_report_time = sample.now_ms;
                            result.cross_event          = EVENT_REPEAT;
                        end
                    end
                    else if (state.cross_flag)
                    begin
                        state_next.cross_flag = 1'b0;
                        result.cross_event    = EVENT_CLEARED;
                    end
                end
            end
        end

        result.cross_warn_active = state_next.cross_flag;
    end

endmodule

FILE: rtl/thermal_safety_supervisor.sv
// Thermal safety supervisor top level: request register, result register,
// configuration registers and supervisor state. Depends on tss_pkg, tss_check.
//
//   Channel  | Handshake                   | Payload
//   ---------+-----------------------------+------------------------------
//   sample   | sample_valid / sample_ready | sample (tss_sample_t)
//   result   | result_valid / result_ready | result (tss_result_t)
//   config   | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// Each request is captured in an input register, tss_check evaluates it, and the
// result register loads it when that register is empty or being read; while result_ready
// is held high, one request per cycle is sustained.
// Reset clears valid flags and supervisor state and loads the register defaults.
// While the result waits, one more request is accepted and held in the input
// register. Configuration writes are always taken.
module thermal_safety_supervisor
    import tss_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_ready,
    input  tss_sample_t               sample,
    output logic                      result_valid,
    input  logic                      result_ready,
    output tss_result_t               result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [TEMP_BITS-1:0]      cfg_data
);

    logic        sample_valid_reg;
    tss_sample_t sample_reg;
    logic        result_valid_reg;
    tss_result_t result_reg;
    tss_cfg_t    cfg_reg;
    tss_cfg_t    cfg_next;
    tss_state_t  state_reg;
    tss_state_t  state_next;
    tss_result_t check_result;
    logic        advance;

    tss_check u_check (
        .sample     (sample_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .result     (check_result),
        .state_next (state_next)
    );

    assign advance      = !result_valid_reg || result_ready;
    assign sample_ready = !sample_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_HOT_FAULT_LIMIT:   cfg_next.hot_fault_limit   = $signed(cfg_data);
                REG_HOT_RATE_LIMIT:    cfg_next.hot_rate_limit    = $signed(cfg_data);
                REG_ALARM_ENTER_LEVEL: cfg_next.alarm_enter_level = $signed(cfg_data);
                REG_ALARM_EXIT_LEVEL:  cfg_next.alarm_exit_level  = $signed(cfg_data);
                REG_WARN_ENTER_LEVEL:  cfg_next.warn_enter_level  = $signed(cfg_data);
                REG_WARN_EXIT_LEVEL:   cfg_next.warn_exit_level   = $signed(cfg_data);
                REG_CROSS_MARGIN:      cfg_next.cross_margin  = cfg_data[MARGIN_BITS-1:0];
                REG_DELTA_PER_AMP:     cfg_next.delta_per_amp = cfg_data[DPA_BITS-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
            cfg_reg.hot_fault_limit   <= HOT_FAULT_LIMIT_RST;
            cfg_reg.hot_rate_limit    <= HOT_RATE_LIMIT_RST;
            cfg_reg.alarm_enter_level <= ALARM_ENTER_LEVEL_RST;
            cfg_reg.alarm_exit_level  <= ALARM_EXIT_LEVEL_RST;
            cfg_reg.warn_enter_level  <= WARN_ENTER_LEVEL_RST;
            cfg_reg.warn_exit_level   <= WARN_EXIT_LEVEL_RST;
            cfg_reg.cross_margin      <= CROSS_MARGIN_RST;
            cfg_reg.delta_per_amp     <= DELTA_PER_AMP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (sample_ready)
                sample_valid_reg <= sample_valid;
            if (advance)
            begin
                result_valid_reg <= sample_valid_reg;
                // State moves only when a request's result is committed.
                if (sample_valid_reg)
                    state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
            sample_reg <= sample;
        if (advance && sample_valid_reg)
            result_reg <= check_result;
    end

endmodule

FILE: tb/tb_thermal_safety_supervisor.sv
// Self-checking testbench for thermal_safety_supervisor: a directed table, then random ticks
// under several register settings and handshake stall patterns; each result is scored against
// a predictor or a hand-computed row. Depends on tss_pkg and the thermal_safety_supervisor RTL.
`timescale 1ns / 1ps

module tb_thermal_safety_supervisor;
    import tss_pkg::*;

    localparam logic [1:0] PHASE_RUN = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int BLOCK_ITEMS = 75;

    // Flag shorthand for the directed table: {cold_err, hot_present, asym, any_supply, rate_ok}.
    localparam bit [4:0] GOOD      = 5'b01010;
    localparam bit [4:0] GOOD_RATE = 5'b01011;

    typedef struct {
        tss_sample_t stim;
        bit          typed;
        tss_result_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        sample_valid = 1'b0;
    logic        sample_ready;
    tss_sample_t sample = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    tss_result_t result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_HOT_FAULT_LIMIT;
    logic [TEMP_BITS-1:0]      cfg_data = '0;

    // Hand-computed expectation travelling with the request it belongs to.
    bit          row_typed = 1'b0;
    tss_result_t row_want = '0;

    // Predictor copy of the registers and supervisor state.
    int hot_limit_cfg   = int'(HOT_FAULT_LIMIT_RST);
    int rate_limit_cfg  = int'(HOT_RATE_LIMIT_RST);
    int alarm_enter_cfg = int'(ALARM_ENTER_LEVEL_RST);
    int alarm_exit_cfg  = int'(ALARM_EXIT_LEVEL_RST);
    int warn_enter_cfg  = int'(WARN_ENTER_LEVEL_RST);
    int warn_exit_cfg   = int'(WARN_EXIT_LEVEL_RST);
    int margin_cfg      = int'(CROSS_MARGIN_RST);
    int dpa_cfg         = int'(DELTA_PER_AMP_RST);
    bit alarm_st = 1'b0;
    bit warning_st = 1'b0;
    bit cross_st = 1'b0;
    logic [TIME_BITS-1:0] last_report_ms = '0;

    tss_result_t predicted_reports[$];
    tss_result_t predicted;
    tss_result_t want;
    int samples_sent = 0;
    int results_seen = 0;
    int errors = 0;
    int cycle_count = 0;
    int sender_idle_pct = 38;
    int stall_pct = 61;
    int cross_streak = 0;
    logic [TIME_BITS-1:0] wall_ms = '0;

    dir_row_t dir_rows[$];

    thermal_safety_supervisor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[thermal_safety_supervisor] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic tss_sample_t smp(input int cold, input int hot, input bit [4:0] flg,
                                        input int rate, input int cur, input logic [1:0] ph,
                                        input logic [31:0] el, input logic [31:0] nw);
        tss_sample_t s;
        s.cold_reading       = TEMP_BITS'(cold);
        s.hot_reading        = TEMP_BITS'(hot);
        s.cold_sensor_error  = flg[4];
        s.hot_sensor_present = flg[3];
        s.supply_asymmetric  = flg[2];
        s.supply_any_present = flg[1];
        s.rate_available     = flg[0];
        s.hot_rise_rate      = TEMP_BITS'(rate);
        s.avg_current_ma     = CUR_BITS'(cur);
        s.phase              = ph;
        s.ramp_elapsed_ms    = el;
        s.now_ms             = nw;
        return s;
    endfunction

    function automatic tss_result_t res(input logic [1:0] st, input logic [3:0] rs,
                                        input int al, input int wn, input int pw,
                                        input int cr, input logic [1:0] ev);
        tss_result_t r;
        r.fault_status      = st;
        r.reason_code       = rs;
        r.hot_alarm         = al[0];
        r.hot_warning       = wn[0];
        r.plausibility_warn = pw[0];
        r.cross_warn_active = cr[0];
        r.cross_event       = ev;
        return r;
    endfunction

    // Computes the report for one tick and advances the predictor state.
    function automatic tss_result_t supervise_tick(input tss_sample_t s);
        int cold;
        int hot;
        int rate;
        int cur;
        bit plaus_skip;
        bit in_grace;
        logic [TIME_BITS-1:0] since;
        tss_result_t r;
        cold = int'(s.cold_reading);
        hot  = int'(s.hot_reading);
        rate = int'(s.hot_rise_rate);
        cur  = int'(s.avg_current_ma);
        r = '0;

        alarm_st   = alarm_st ? (hot >= alarm_exit_cfg) : (hot >= alarm_enter_cfg);
        warning_st = warning_st ? (hot >= warn_exit_cfg) : (hot >= warn_enter_cfg);

        if (s.cold_sensor_error)
        begin
            r.fault_status = STATUS_SENSOR;
            r.reason_code  = REASON_COLD_ERROR;
        end
        else if (!s.hot_sensor_present)
        begin
            r.fault_status = STATUS_SENSOR;
            r.reason_code  = REASON_HOT_MISSING;
        end

        // A range fault has the same severity as a sensor fault, so the earlier reason stays.
        if (r.fault_status == STATUS_OK)
        begin
            r.fault_status = STATUS_SENSOR;
            if (cold < COLD_MIN_VALID)
                r.reason_code = REASON_COLD_LOW;
            else if (cold > COLD_MAX_VALID)
                r.reason_code = REASON_COLD_HIGH;
            else if (hot < HOT_MIN_VALID)
                r.reason_code = REASON_HOT_LOW;
            else if (hot > HOT_MAX_VALID)
                r.reason_code = REASON_HOT_HIGH;
            else
                r.fault_status = STATUS_OK;
        end

        if (hot >= hot_limit_cfg)
        begin
            r.fault_status = STATUS_THERMAL;
            r.reason_code  = REASON_HOT_LIMIT;
        end
        else if (s.rate_available && rate > rate_limit_cfg)
        begin
            r.fault_status = STATUS_THERMAL;
            r.reason_code  = REASON_RUNAWAY;
        end

        if (r.fault_status != STATUS_THERMAL)
        begin
            if (s.supply_asymmetric)
            begin
                r.fault_status = STATUS_SUPPLY;
                r.reason_code  = REASON_SUPPLY_ASYM;
            end
            else if (!s.supply_any_present)
            begin
                r.fault_status = STATUS_SUPPLY;
                r.reason_code  = REASON_SUPPLY_ABSENT;
            end
        end

        if (r.fault_status == STATUS_OK)
        begin
            plaus_skip = (s.phase == PHASE_STARTUP) ||
                         (s.phase == PHASE_RAMP_UP && s.ramp_elapsed_ms < PLAUS_GRACE_MS);
            if (!plaus_skip && cold <= PLAUS_COLD_MAX && cur >= 500 && hot < PLAUS_HOT_THRESH)
            begin
                // Delta in tenths against current in mA times tenths per ampere.
                if ((hot - cold) * 1000 < cur * dpa_cfg)
                begin
                    r.fault_status = STATUS_THERMAL;
                    r.reason_code  = REASON_IMPLAUSIBLE;
                end
                else
                    r.plausibility_warn = 1'b1;
            end
            if (r.fault_status == STATUS_OK)
            begin
                in_grace = (s.phase == PHASE_SELF_TEST) || (s.phase == PHASE_STARTUP) ||
                           (s.phase == PHASE_RAMP_UP && s.ramp_elapsed_ms < CROSS_GRACE_MS);
                if (!in_grace)
                begin
                    since = s.now_ms - last_report_ms;
                    if (cold >= hot - margin_cfg)
                    begin
                        if (!cross_st)
                        begin
                            cross_st       = 1'b1;
                            last_report_ms = s.now_ms;
                            r.cross_event  = EVENT_ENTERED;
                        end
                        else if (since >= REPORT_INTERVAL_MS)
                        begin
                            last_report_ms = s.now_ms;
                            r.cross_event  = EVENT_REPEAT;
                        end
                    end
                    else if (cross_st)
                    begin
                        cross_st      = 1'b0;
                        r.cross_event = EVENT_CLEARED;
                    end
                end
            end
        end

        r.hot_alarm         = alarm_st;
        r.hot_warning       = warning_st;
        r.cross_warn_active = cross_st;
        return r;
    endfunction

    function automatic tss_sample_t random_sample();
        tss_sample_t s;
        int lvl;
        s.cold_reading       = TEMP_BITS'($urandom);
        s.hot_reading        = TEMP_BITS'($urandom);
        s.cold_sensor_error  = 1'($urandom);
        s.hot_sensor_present = 1'($urandom);
        s.supply_asymmetric  = 1'($urandom);
        s.supply_any_present = 1'($urandom);
        s.rate_available     = 1'($urandom);
        s.hot_rise_rate      = TEMP_BITS'($urandom);
        s.avg_current_ma     = CUR_BITS'($urandom);
        s.phase              = 2'($urandom);
        s.ramp_elapsed_ms    = $urandom;
        s.now_ms             = $urandom;
        if ($urandom_range(99) < 25)
            return s;

        // Healthy tick, so that the plausibility and cross checks get exercised.
        s.cold_sensor_error  = 1'b0;
        s.hot_sensor_present = 1'b1;
        s.supply_asymmetric  = 1'b0;
        s.supply_any_present = 1'b1;
        s.hot_rise_rate = TEMP_BITS'(int'($urandom_range(0, 160)) - 80);
        s.hot_reading   = TEMP_BITS'(int'($urandom_range(0, 1200)) - 550);
        s.cold_reading  = TEMP_BITS'(int'($urandom_range(0, 1500)) - 700);
        if ($urandom_range(1))
            s.avg_current_ma = CUR_BITS'($urandom_range(0, 3000));

        // Runs of cold-near-hot ticks so that repeat reports come due.
        if (cross_streak == 0 && $urandom_range(4) == 0)
            cross_streak = $urandom_range(2, 8);
        if (cross_streak > 0)
        begin
            cross_streak = cross_streak - 1;
            s.cold_reading = TEMP_BITS'(int'(s.hot_reading) - margin_cfg +
                                        int'($urandom_range(0, 20)) - 10);
        end
        else
        begin
            case ($urandom_range(3))
                0:
                begin
                    s.cold_reading = TEMP_BITS'(int'($urandom_range(0, 250)) - 720);
                    s.hot_reading  = TEMP_BITS'(int'(s.cold_reading) +
                                                int'($urandom_range(0, 300)));
                    s.avg_current_ma = CUR_BITS'($urandom_range(300, 4000));
                end
                1:
                begin
                    case ($urandom_range(3))
                        0:       lvl = alarm_enter_cfg;
                        1:       lvl = alarm_exit_cfg;
                        2:       lvl = warn_enter_cfg;
                        default: lvl = warn_exit_cfg;
                    endcase
                    s.hot_reading = TEMP_BITS'(lvl + int'($urandom_range(0, 6)) - 3);
                end
                2:
                begin
                    case ($urandom_range(5))
                        0:       s.hot_reading = TEMP_BITS'(-551);
                        1:       s.hot_reading = TEMP_BITS'(1251);
                        2:       s.hot_reading = TEMP_BITS'(hot_limit_cfg);
                        3:       s.hot_reading = TEMP_BITS'(hot_limit_cfg - 1);
                        4:       s.cold_reading = TEMP_BITS'(-701);
                        default: s.cold_reading = TEMP_BITS'(801);
                    endcase
                end
                default: ;
            endcase
        end

        case ($urandom_range(9))
            0: s.phase = PHASE_SELF_TEST;
            1: s.phase = PHASE_STARTUP;
            2, 3:
            begin
                s.phase = PHASE_RAMP_UP;
                case ($urandom_range(2))
                    0:       s.ramp_elapsed_ms = $urandom_range(175000, 185000);
                    1:       s.ramp_elapsed_ms = $urandom_range(295000, 305000);
                    default: ;
                endcase
            end
            default: s.phase = PHASE_RUN;
        endcase

        if ($urandom_range(49) == 0)
            wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 100000);
        else
            wall_ms = wall_ms + $urandom_range(0, 45000);
        s.now_ms = wall_ms;
        return s;
    endfunction

    // Called at a clock edge; returns at the edge where the request is taken.
    task automatic send_sample(input tss_sample_t stim, input bit typed, input tss_result_t exp_r);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            sample_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        sample_valid <= 1'b1;
        sample       <= stim;
        row_typed    <= typed;
        row_want     <= exp_r;
        do
            @(posedge clk);
        while (!sample_ready);
        samples_sent = samples_sent + 1;
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (results_seen < samples_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[TEMP_BITS-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_settings(input int hot_limit, input int rate_limit,
                                 input int alarm_enter, input int alarm_exit,
                                 input int warn_enter, input int warn_exit,
                                 input int margin, input int dpa);
        write_reg(REG_HOT_FAULT_LIMIT, hot_limit);
        write_reg(REG_HOT_RATE_LIMIT, rate_limit);
        write_reg(REG_ALARM_ENTER_LEVEL, alarm_enter);
        write_reg(REG_ALARM_EXIT_LEVEL, alarm_exit);
        write_reg(REG_WARN_ENTER_LEVEL, warn_enter);
        write_reg(REG_WARN_EXIT_LEVEL, warn_exit);
        write_reg(REG_CROSS_MARGIN, margin);
        write_reg(REG_DELTA_PER_AMP, dpa);
        cfg_valid <= 1'b0;
    endtask

    // Scoreboard: register writes, result checks, then prediction for newly taken requests.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_HOT_FAULT_LIMIT:   hot_limit_cfg   = int'($signed(cfg_data));
                    REG_HOT_RATE_LIMIT:    rate_limit_cfg  = int'($signed(cfg_data));
                    REG_ALARM_ENTER_LEVEL: alarm_enter_cfg = int'($signed(cfg_data));
                    REG_ALARM_EXIT_LEVEL:  alarm_exit_cfg  = int'($signed(cfg_data));
                    REG_WARN_ENTER_LEVEL:  warn_enter_cfg  = int'($signed(cfg_data));
                    REG_WARN_EXIT_LEVEL:   warn_exit_cfg   = int'($signed(cfg_data));
                    REG_CROSS_MARGIN:      margin_cfg      = int'(cfg_data[MARGIN_BITS-1:0]);
                    REG_DELTA_PER_AMP:     dpa_cfg         = int'(cfg_data[DPA_BITS-1:0]);
                    default: ;
                endcase
            end

            if (result_valid && result_ready)
            begin
                results_seen = results_seen + 1;
                if (predicted_reports.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors = errors + 1;
                end
                else
                begin
                    want = predicted_reports.pop_front();
                    if (result.fault_status !== want.fault_status)
                    begin
                        $error("fault_status: expected %0d, got %0d",
                               want.fault_status, result.fault_status);
                        errors = errors + 1;
                    end
                    if (result.reason_code !== want.reason_code)
                    begin
                        $error("reason_code: expected %0d, got %0d",
                               want.reason_code, result.reason_code);
                        errors = errors + 1;
                    end
                    if (result.hot_alarm !== want.hot_alarm)
                    begin
                        $error("hot_alarm: expected %0d, got %0d",
                               want.hot_alarm, result.hot_alarm);
                        errors = errors + 1;
                    end
                    if (result.hot_warning !== want.hot_warning)
                    begin
                        $error("hot_warning: expected %0d, got %0d",
                               want.hot_warning, result.hot_warning);
                        errors = errors + 1;
                    end
                    if (result.plausibility_warn !== want.plausibility_warn)
                    begin
                        $error("plausibility_warn: expected %0d, got %0d",
                               want.plausibility_warn, result.plausibility_warn);
                        errors = errors + 1;
                    end
                    if (result.cross_warn_active !== want.cross_warn_active)
                    begin
                        $error("cross_warn_active: expected %0d, got %0d",
                               want.cross_warn_active, result.cross_warn_active);
                        errors = errors + 1;
                    end
                    if (result.cross_event !== want.cross_event)
                    begin
                        $error("cross_event: expected %0d, got %0d",
                               want.cross_event, result.cross_event);
                        errors = errors + 1;
                    end
                end
            end

            if (sample_valid && sample_ready)
            begin
                predicted = supervise_tick(sample);
                predicted_reports.push_back(row_typed ? row_want : predicted);
            end
        end
    end

    initial
    begin
        int lvl;
        int wlvl;

        // Directed table, run with the reset register values.
        dir_rows.push_back('{smp(0, 300, GOOD, 0, 0, PHASE_SELF_TEST, 0, 0), 1'b1,
            res(STATUS_OK, REASON_NONE, 0, 0, 0, 0, EVENT_NONE)});
        dir_rows.push_back('{smp(0, 300, 5'b10010, 0, 0, PHASE_SELF_TEST, 0, 0), 1'b1,
            res(STATUS_SENSOR, REASON_COLD_ERROR, 0, 0, 0, 0, EVENT_NONE)});
        dir_rows.push_back('{smp(0, 300, 5'b00010, 0, 0, PHASE_SELF_TEST, 0, 0), 1'b1,
            res(STATUS_SENSOR, REASON_HOT_MISSING, 0, 0, 0, 0, EVENT_NONE)});
        // Equal severity: the sensor reason found first is kept over the range reason.
        dir_rows.push_back('{smp(-2048, 300, 5'b11010, 0, 0, PHASE_SELF_TEST, 0, 0), 1'b1,
            res(STATUS_SENSOR, REASON_COLD_ERROR, 0, 0, 0, 0, EVENT_NONE)});
        dir_rows.push_back('{smp(-701, 300, GOOD, 0, 0, PHASE_SELF_TEST, 0, 0), 1'b1,
            res(STATUS_SENSOR, REASON_COLD_LOW, 0, 0, 0, 0, EVENT_NONE)});
        dir_rows.push_back('{smp(2047, -2048, GOOD, 0, 0, PHASE_SELF_TEST, 0, 0), 1'b1,
            res(STATUS_SENSOR, REASON_COLD_HIGH, 0, 0, 0, 0, EVENT_NONE)});
        dir_rows.push_back('{smp(0, -551, GOOD, 0, 0, PHASE_SELF_TEST, 0, 0), 1'b1,
            res(STATUS_SENSOR, REASON_HOT_LOW, 0, 0, 0, 0, EVENT_NONE)});
        dir_rows.push_back('{smp(0, 300, GOOD_RATE, 51, 0, PHASE_SELF_TEST, 0, 0), 1'b1,
            res(STATUS_THERMAL, REASON_RUNAWAY, 0, 0, 0, 0, EVENT_NONE)});
        dir_rows.push_back('{smp(0, 300, GOOD_RATE, 50, 0, PHASE_SELF_TEST, 0, 0), 1'b1,
            res(STATUS_OK, REASON_NONE, 0, 0, 0, 0, EVENT_NONE)});
        dir_rows.push_back('{smp(0, 300, 5'b01100, 0, 0, PHASE_SELF_TEST, 0, 0), 1'b1,
            res(STATUS_SUPPLY, REASON_SUPPLY_ASYM, 0, 0, 0, 0, EVENT_NONE)});
        dir_rows.push_back('{smp(0, 300, 5'b01000, 0, 0, PHASE_SELF_TEST, 0, 0), 1'b1,
            res(STATUS_SUPPLY, REASON_SUPPLY_ABSENT, 0, 0, 0, 0, EVENT_NONE)});
        dir_rows.push_back('{smp(0, 300, 5'b10110, 0, 0, PHASE_SELF_TEST, 0, 0), 1'b1,
            res(STATUS_SUPPLY, REASON_SUPPLY_ASYM, 0, 0, 0, 0, EVENT_NONE)});
        dir_rows.push_back('{smp(-500, -490, GOOD, 0, 1000, PHASE_RUN, 0, 0), 1'b1,
            res(STATUS_THERMAL, REASON_IMPLAUSIBLE, 0, 0, 0, 0, EVENT_NONE)});
        dir_rows.push_back('{smp(-600, 100, GOOD, 0, 32767, PHASE_RUN, 0, 0), 1'b1,
            res(STATUS_OK, REASON_NONE, 0, 0, 1, 0, EVENT_NONE)});
        dir_rows.push_back('{smp(-500, -490, GOOD, 0, 1000, PHASE_RAMP_UP, 179999, 0), 1'b1,
            res(STATUS_OK, REASON_NONE, 0, 0, 0, 0, EVENT_NONE)});
        dir_rows.push_back('{smp(-500, -490, GOOD, 0, 1000, PHASE_RAMP_UP, 180000, 0), 1'b1,
            res(STATUS_THERMAL, REASON_IMPLAUSIBLE, 0, 0, 0, 0, EVENT_NONE)});
        dir_rows.push_back('{smp(290, 300, GOOD, 0, 0, PHASE_RUN, 0, 1000), 1'b1,
            res(STATUS_OK, REASON_NONE, 0, 0, 0, 1, EVENT_ENTERED)});
        dir_rows.push_back('{smp(290, 300, GOOD, 0, 0, PHASE_RUN, 0, 60999), 1'b1,
            res(STATUS_OK, REASON_NONE, 0, 0, 0, 1, EVENT_NONE)});
        dir_rows.push_back('{smp(290, 300, GOOD, 0, 0, PHASE_RUN, 0, 61000), 1'b1,
            res(STATUS_OK, REASON_NONE, 0, 0, 0, 1, EVENT_REPEAT)});
        dir_rows.push_back('{smp(0, 300, GOOD, 0, 0, PHASE_RUN, 0, 200000), 1'b1,
            res(STATUS_OK, REASON_NONE, 0, 0, 0, 0, EVENT_CLEARED)});
        // Repeat interval measured across the wrap of the millisecond counter.
        dir_rows.push_back('{smp(290, 300, GOOD, 0, 0, PHASE_RUN, 0, 32'hFFFF_F000), 1'b0, '0});
        dir_rows.push_back('{smp(290, 300, GOOD, 0, 0, PHASE_RUN, 0, 55904), 1'b0, '0});
        dir_rows.push_back('{smp(0, 700, GOOD, 0, 0, PHASE_SELF_TEST, 0, 0), 1'b0, '0});
        dir_rows.push_back('{smp(0, 549, GOOD, 0, 0, PHASE_SELF_TEST, 0, 0), 1'b0, '0});
        dir_rows.push_back('{smp(0, 449, GOOD, 0, 0, PHASE_SELF_TEST, 0, 0), 1'b0, '0});
        dir_rows.push_back('{smp(2047, 2047, 5'b11111, 2047, 32767, PHASE_RUN,
            32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_sample(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

        for (int blk = 0; blk < 6; blk++)
        begin
            drain();
            sender_idle_pct = (blk < 2) ? 38 : (blk < 4) ? 61 : 0;
            stall_pct       = (blk < 2) ? 61 : (blk < 4) ? 38 : 0;
            case (blk)
                1: load_settings(-2048, -2048, -2048, -2048, -2048, -2048, 0, 0);
                2: load_settings(800, 30, 500, 650, 300, 420, 15, 40);
                3: load_settings(2047, 2047, 2047, 2047, 2047, 2047, 2047, 255);
                4:
                begin
                    lvl  = int'($urandom_range(0, 1800)) - 600;
                    wlvl = int'($urandom_range(0, 1800)) - 600;
                    load_settings(int'($urandom_range(400, 1500)),
                                  int'($urandom_range(0, 200)) - 100,
                                  lvl, lvl - int'($urandom_range(0, 100)),
                                  wlvl, wlvl - int'($urandom_range(0, 100)),
                                  int'($urandom_range(0, 200)), int'($urandom_range(0, 255)));
                end
                5: load_settings(HOT_FAULT_LIMIT_RST, HOT_RATE_LIMIT_RST, ALARM_ENTER_LEVEL_RST,
                                 ALARM_EXIT_LEVEL_RST, WARN_ENTER_LEVEL_RST, WARN_EXIT_LEVEL_RST,
                                 CROSS_MARGIN_RST, DELTA_PER_AMP_RST);
                default: ;
            endcase
            repeat (BLOCK_ITEMS)
                send_sample(random_sample(), 1'b0, '0);
        end

        drain();
        if (predicted_reports.size() != 0)
        begin
            $error("%0d expected results never arrived", predicted_reports.size());
            errors = errors + 1;
        end
        if (errors == 0)
            $display("[thermal_safety_supervisor] OK");
        else
            $display("[thermal_safety_supervisor] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tss_pkg.sv
rtl/tss_check.sv
rtl/thermal_safety_supervisor.sv
tb/tb_thermal_safety_supervisor.sv
